@@ rtl/talr_pkg.sv @@
package talr_pkg;

    localparam int DEPTH       = 256;
    localparam int SLOT_W      = $clog2(DEPTH);
    localparam int MAX_SAMPLES = 64;
    localparam int QUEUE_DEPTH = 2;

    localparam logic signed [17:0] PI_Q12     = 18'sd12868;
    localparam logic signed [17:0] TWO_PI_Q12 = 18'sd25736;
    localparam logic [47:0]        DIST_MAX   = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        OP_PLOT   = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_HAS    = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // One classified item as it travels from the front to the back part.
    typedef struct packed {
        op_t                  op;
        logic signed [31:0]   px;
        logic signed [31:0]   py;
        logic signed [15:0]   ang;
        logic signed [48:0]   qd;
        logic [31:0]          step;
        logic [6:0]           count;
    } cmd_t;

    // One stored segment: both end points, both headings, both distances.
    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
        logic signed [15:0] a1;
        logic signed [15:0] a2;
        logic [47:0]        sd;
        logic [47:0]        ed;
    } seg_t;

    localparam int SEG_W = $bits(seg_t);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PL_RD,
        ST_PL_WAIT,
        ST_PL_SQ0,
        ST_PL_SQ1,
        ST_PL_ROOT,
        ST_PL_WR,
        ST_HAS,
        ST_SM_RD,
        ST_SM_WAIT,
        ST_SM_CHK,
        ST_SM_DIV,
        ST_SM_MUL,
        ST_SM_OUT,
        ST_SM_EMPTY
    } state_t;

endpackage

@@ rtl/trail_arc_length_resampler_top.sv @@
// Channel | Handshake            | Beat contents
// input   | in_valid / in_ready  | operation, pos_x, pos_y, angle_in, query_distance, interval,
//         |                      | sample_count
// output  | out_valid/ out_ready | out_x, out_y, out_angle, valid_res, present, last_of_run
//
// A plot is dominated by the bit-serial square root (34 steps).
// A has-node query can be held up by output stalls.
// A sample point runs the 17-step divider unless t clamps, and each segment walked back
// adds another read and check before the point.
// Reset clears the queue, the slot pointer and the node count; segment memory is not cleared.
// A two-entry queue lets the front accept beats while the back is busy or stalled.
module trail_arc_length_resampler_top
    import talr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [15:0] angle_in,
    input  logic [48:0] query_distance,
    input  logic [31:0] interval,
    input  logic [6:0]  sample_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_x,
    output logic [31:0] out_y,
    output logic [15:0] out_angle,
    output logic        valid_res,
    output logic        present,
    output logic        last_of_run
);

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    talr_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .angle_in       (angle_in),
        .query_distance (query_distance),
        .interval       (interval),
        .sample_count   (sample_count),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .cmd            (cmd)
    );

    talr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_angle   (out_angle),
        .valid_res   (valid_res),
        .present     (present),
        .last_of_run (last_of_run)
    );

endmodule

@@ rtl/talr_ram.sv @@
module talr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/talr_front.sv @@
module talr_front
    import talr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [15:0] angle_in,
    input  logic [48:0] query_distance,
    input  logic [31:0] interval,
    input  logic [6:0]  sample_count,
    output logic        cmd_valid,
    input  logic        cmd_ready,
    output cmd_t        cmd
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    cmd_t             q_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   fill_reg;
    cmd_t             cmd_in;
    logic             keep;
    logic             push;
    logic             pop;

    // Classify the beat: unused codes and empty sample runs are dropped here.
    always_comb
    begin
        cmd_in.op    = op_t'(operation);
        cmd_in.px    = pos_x;
        cmd_in.py    = pos_y;
        cmd_in.ang   = angle_in;
        cmd_in.qd    = query_distance;
        cmd_in.step  = interval;
        cmd_in.count = (sample_count > 7'(MAX_SAMPLES)) ? 7'(MAX_SAMPLES) : sample_count;
        keep = (cmd_in.op != OP_NONE) && !(cmd_in.op == OP_SAMPLE && sample_count == 7'd0);
    end

    assign in_ready  = (fill_reg != (PTR_W+1)'(QUEUE_DEPTH));
    assign push      = in_valid && in_ready && keep;
    assign cmd_valid = (fill_reg != '0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_mem[rd_ptr_reg];

    // Queue payload.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cmd_in;
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
        end
    end

endmodule

@@ rtl/talr_back.sv @@
module talr_back
    import talr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  cmd_t        cmd,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_x,
    output logic [31:0] out_y,
    output logic [15:0] out_angle,
    output logic        valid_res,
    output logic        present,
    output logic        last_of_run
);

    state_t              state_reg, state_next;
    cmd_t                cmd_reg;
    logic [SLOT_W-1:0]   newest_reg;
    logic [SLOT_W-1:0]   count_reg;
    logic [SLOT_W-1:0]   k_reg;
    logic [6:0]          idx_reg;
    logic signed [49:0]  dist_reg;
    seg_t                rd_seg;
    seg_t                seg_reg;
    seg_t                wr_seg;
    logic                we;
    logic [SLOT_W-1:0]   raddr;
    logic [SLOT_W-1:0]   waddr;
    logic [32:0]         adx_reg, ady_reg;
    logic [65:0]         sq_reg;
    logic [33:0]         root_reg;
    logic [5:0]          bit_reg;
    logic [47:0]         d1_reg;
    logic [16:0]         t_reg;
    logic [48:0]         num_reg;
    logic [48:0]         den_reg;
    logic [16:0]         quo_reg;
    logic [4:0]          dcnt_reg;
    logic signed [51:0]  px_reg, py_reg, pa_reg;
    logic                obuf_full_reg;

    logic signed [49:0]  st_s, en_s;
    logic                step_back;
    logic [33:0]         cand;
    logic [67:0]         cand_sq;
    logic [48:0]         rem_sh;
    logic signed [32:0]  dxs, dys;
    logic signed [17:0]  adiff;
    logic signed [33:0]  ldx, ldy;
    logic [48:0]         dsum;
    logic                out_load;

    talr_ram #(.WIDTH(SEG_W), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wr_seg),
        .raddr (raddr),
        .rdata (rd_seg)
    );

    assign cmd_ready = (state_reg == ST_IDLE);
    assign out_valid = obuf_full_reg;
    assign st_s      = $signed({2'b00, rd_seg.sd});
    assign en_s      = $signed({2'b00, rd_seg.ed});
    assign step_back = ({1'b0, k_reg} + 1'b1 < {1'b0, count_reg}) && (dist_reg < st_s);
    assign cand      = root_reg | (34'd1 << bit_reg);
    assign cand_sq   = 68'(cand) * 68'(cand);
    assign rem_sh    = {num_reg[47:0], 1'b0};
    assign dxs       = 33'(cmd_reg.px) - 33'(seg_reg.ex);
    assign dys       = 33'(cmd_reg.py) - 33'(seg_reg.ey);
    assign dsum      = {1'b0, d1_reg} + {15'd0, root_reg};
    assign raddr     = (state_reg == ST_SM_CHK && step_back) ? newest_reg - k_reg - 1'b1
                                                              : newest_reg - k_reg;
    assign waddr     = newest_reg + 1'b1;

    // Heading difference with one wrap in each direction.
    always_comb
    begin
        adiff = 18'(rd_seg.a2) - 18'(rd_seg.a1);
        if (adiff > PI_Q12)
        begin
            adiff = adiff - TWO_PI_Q12;
        end
        if (adiff < -PI_Q12)
        begin
            adiff = adiff + TWO_PI_Q12;
        end
        ldx = 34'(seg_reg.ex) - 34'(seg_reg.sx);
        ldy = 34'(seg_reg.ey) - 34'(seg_reg.sy);
    end

    // Segment built by a plot.
    always_comb
    begin
        if (count_reg != '0)
        begin
            wr_seg.sx = seg_reg.ex;
            wr_seg.sy = seg_reg.ey;
            wr_seg.a1 = seg_reg.a2;
        end
        else
        begin
            wr_seg.sx = cmd_reg.px;
            wr_seg.sy = cmd_reg.py;
            wr_seg.a1 = cmd_reg.ang;
        end
        wr_seg.ex = cmd_reg.px;
        wr_seg.ey = cmd_reg.py;
        wr_seg.a2 = cmd_reg.ang;
        wr_seg.sd = d1_reg;
        wr_seg.ed = dsum[48] ? DIST_MAX : dsum[47:0];
        we        = (state_reg == ST_PL_WR);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.op)
                        OP_PLOT:   state_next = ST_PL_RD;
                        OP_SAMPLE: state_next = ST_SM_RD;
                        OP_HAS:    state_next = ST_PL_RD;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PL_RD:    state_next = ST_PL_WAIT;
            ST_PL_WAIT:  state_next = (cmd_reg.op == OP_HAS) ? ST_HAS : ST_PL_SQ0;
            ST_PL_SQ0:   state_next = ST_PL_SQ1;
            ST_PL_SQ1:   state_next = ST_PL_ROOT;
            ST_PL_ROOT:  state_next = (bit_reg == 6'd0) ? ST_PL_WR : ST_PL_ROOT;
            ST_PL_WR:    state_next = ST_IDLE;
            ST_HAS:      state_next = !obuf_full_reg ? ST_IDLE : ST_HAS;
            ST_SM_RD:    state_next = (count_reg == '0) ? ST_SM_EMPTY : ST_SM_WAIT;
            ST_SM_WAIT:  state_next = ST_SM_CHK;
            ST_SM_CHK:   state_next = step_back ? ST_SM_WAIT : ST_SM_DIV;
            ST_SM_DIV:   state_next = (dcnt_reg == 5'd0) ? ST_SM_MUL : ST_SM_DIV;
            ST_SM_MUL:   state_next = ST_SM_OUT;
            ST_SM_OUT,
            ST_SM_EMPTY:
            begin
                if (!obuf_full_reg)
                begin
                    if (idx_reg + 7'd1 == cmd_reg.count)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = (state_reg == ST_SM_EMPTY) ? ST_SM_EMPTY : ST_SM_WAIT;
                    end
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    assign out_load = !obuf_full_reg &&
                      (state_reg == ST_HAS || state_reg == ST_SM_OUT || state_reg == ST_SM_EMPTY);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            newest_reg    <= '1;
            count_reg     <= '0;
            obuf_full_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_PL_WR)
            begin
                newest_reg <= waddr;
                if (count_reg != SLOT_W'(DEPTH-1))
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (out_load)
            begin
                obuf_full_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                obuf_full_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_reg  <= cmd;
                k_reg    <= '0;
                idx_reg  <= '0;
                dist_reg <= 50'(cmd.qd);
            end
            ST_PL_WAIT:
            begin
                seg_reg <= rd_seg;
                d1_reg  <= (count_reg != '0) ? rd_seg.ed : '0;
            end
            ST_PL_SQ0:
            begin
                if (count_reg == '0)
                begin
                    adx_reg <= '0;
                    ady_reg <= '0;
                end
                else
                begin
                    adx_reg <= dxs[32] ? 33'(-dxs) : 33'(dxs);
                    ady_reg <= dys[32] ? 33'(-dys) : 33'(dys);
                end
            end
            ST_PL_SQ1:
            begin
                sq_reg   <= 66'(adx_reg) * 66'(adx_reg) + 66'(ady_reg) * 66'(ady_reg);
                root_reg <= '0;
                bit_reg  <= 6'd33;
            end
            ST_PL_ROOT:
            begin
                if (cand_sq <= 68'(sq_reg))
                begin
                    root_reg <= cand;
                end
                bit_reg <= bit_reg - 1'b1;
            end
            ST_SM_CHK:
            begin
                if (step_back)
                begin
                    k_reg <= k_reg + 1'b1;
                end
                else
                begin
                    seg_reg <= rd_seg;
                    pa_reg  <= 52'(rd_seg.a1) <<< 16;
                    px_reg  <= 52'(adiff);
                    num_reg <= 49'(dist_reg - st_s);
                    den_reg <= 49'(en_s - st_s);
                    quo_reg <= '0;
                    dcnt_reg <= 5'd17;
                    if (dist_reg <= 0 || dist_reg <= st_s)
                    begin
                        t_reg    <= 17'd0;
                        dcnt_reg <= 5'd0;
                    end
                    else if (dist_reg >= en_s)
                    begin
                        t_reg    <= 17'd65536;
                        dcnt_reg <= 5'd0;
                    end
                    else
                    begin
                        t_reg <= 17'd0;
                    end
                end
            end
            ST_SM_DIV:
            begin
                // Restoring division, one quotient bit a cycle.
                if (dcnt_reg != 5'd0)
                begin
                    if (dcnt_reg == 5'd17)
                    begin
                        quo_reg <= '0;
                    end
                    else if (rem_sh >= den_reg)
                    begin
                        num_reg <= rem_sh - den_reg;
                        quo_reg <= {quo_reg[15:0], 1'b1};
                    end
                    else
                    begin
                        num_reg <= rem_sh;
                        quo_reg <= {quo_reg[15:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg - 1'b1;
                end
                else if (t_reg == 17'd0 && den_reg != '0 && dist_reg > 0
                         && dist_reg < $signed({1'b0, den_reg}) + $signed({2'b00, seg_reg.sd})
                         && dist_reg > $signed({2'b00, seg_reg.sd}))
                begin
                    t_reg <= quo_reg;
                end
            end
            ST_SM_MUL:
            begin
                px_reg <= 52'(ldx * $signed({1'b0, t_reg})) + 52'sd32768;
                py_reg <= 52'(ldy * $signed({1'b0, t_reg})) + 52'sd32768;
                pa_reg <= 52'($signed(px_reg[17:0]) * $signed({1'b0, t_reg})) + 52'sd32768;
            end
            ST_SM_OUT,
            ST_SM_EMPTY:
            begin
                if (!obuf_full_reg)
                begin
                    idx_reg  <= idx_reg + 1'b1;
                    dist_reg <= dist_reg - $signed({18'd0, cmd_reg.step});
                end
            end
            default:
            begin
            end
        endcase
    end

    // Output register, loaded once per result beat.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            unique case (state_reg)
                ST_HAS:
                begin
                    out_x       <= '0;
                    out_y       <= '0;
                    out_angle   <= '0;
                    valid_res   <= (count_reg != '0);
                    present     <= (count_reg != '0) &&
                                   ($signed(cmd_reg.qd) <= $signed({1'b0, seg_reg.ed}));
                    last_of_run <= 1'b1;
                end
                ST_SM_OUT:
                begin
                    out_x       <= seg_reg.sx + 32'(px_reg >>> 16);
                    out_y       <= seg_reg.sy + 32'(py_reg >>> 16);
                    out_angle   <= seg_reg.a1 + 16'(pa_reg >>> 16);
                    valid_res   <= 1'b1;
                    present     <= 1'b0;
                    last_of_run <= (idx_reg + 7'd1 == cmd_reg.count);
                end
                default:
                begin
                    out_x       <= '0;
                    out_y       <= '0;
                    out_angle   <= '0;
                    valid_res   <= 1'b0;
                    present     <= 1'b0;
                    last_of_run <= (idx_reg + 7'd1 == cmd_reg.count);
                end
            endcase
        end
    end

endmodule

@@ verif/talr_checker.sv @@
// Watches both channels of the trail resampler, keeps its own copy of the
// path, predicts every result beat and compares it with what comes out.
module talr_checker
    import talr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [15:0] angle_in,
    input  logic [48:0] query_distance,
    input  logic [31:0] interval,
    input  logic [6:0]  sample_count,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] out_x,
    input  logic [31:0] out_y,
    input  logic [15:0] out_angle,
    input  logic        valid_res,
    input  logic        present,
    input  logic        last_of_run,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [15:0] ang;
        logic        vld;
        logic        pres;
        logic        last;
    } point_t;

    // Model of the segment ring.
    seg_t       trail [DEPTH];
    int         newest;
    int         nodes;
    point_t     expected_points [$];

    assign pending = expected_points.size();

    // Floor square root of a 128-bit sum of squares, bit by bit.
    function automatic logic [47:0] isqrt(input logic [127:0] v);
        logic [47:0]  r;
        logic [47:0]  c;
        r = '0;
        for (int b = 33; b >= 0; b--)
        begin
            c = r | (48'd1 << b);
            if ({80'd0, c} * {80'd0, c} <= v)
                r = c;
        end
        return r;
    endfunction

    // a + round_half_up(diff * t / 65536), arithmetic shift floors.
    function automatic longint blend(input longint a, input longint diff, input longint t);
        longint p;
        p = diff * t + 32768;
        return a + (p >>> 16);
    endfunction

    task automatic add_segment(input logic [31:0] px, input logic [31:0] py,
                               input logic [15:0] ang);
        seg_t        s;
        longint      dx;
        longint      dy;
        logic [127:0] sq;
        logic [48:0] d2;
        s.sx = px; s.sy = py; s.a1 = ang; s.sd = '0;
        if (nodes > 0)
        begin
            s.sx = trail[newest].ex;
            s.sy = trail[newest].ey;
            s.a1 = trail[newest].a2;
            s.sd = trail[newest].ed;
        end
        dx = longint'($signed(px)) - longint'(s.sx);
        dy = longint'($signed(py)) - longint'(s.sy);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        sq = {64'd0, dx} * {64'd0, dx} + {64'd0, dy} * {64'd0, dy};
        d2 = {1'b0, s.sd} + {1'b0, isqrt(sq)};
        s.ed = d2[48] ? DIST_MAX : d2[47:0];
        s.ex = px; s.ey = py; s.a2 = ang;
        newest = (newest + 1) % DEPTH;
        trail[newest] = s;
        if (nodes < DEPTH - 1)
            nodes++;
    endtask

    task automatic predict_samples(input logic signed [48:0] qd, input logic [31:0] step,
                                   input logic [6:0] cnt);
        int          n;
        int          k;
        int          slot;
        longint      walk_dist;
        longint      st;
        longint      en;
        longint      t;
        longint      diff;
        seg_t        s;
        point_t      p;
        n = (cnt > MAX_SAMPLES) ? MAX_SAMPLES : cnt;
        walk_dist = qd;
        k = 0;
        for (int i = 0; i < n; i++)
        begin
            p = '0;
            p.last = (i == n - 1);
            if (nodes > 0)
            begin
                while (k + 1 < nodes &&
                       walk_dist < longint'(trail[(newest + DEPTH - k) % DEPTH].sd))
                    k++;
                slot = (newest + DEPTH - k) % DEPTH;
                s = trail[slot];
                st = s.sd;
                en = s.ed;
                // The shifted span can exceed 2^63, so the quotient is taken unsigned.
                if (walk_dist <= 0 || walk_dist <= st)
                    t = 0;
                else if (walk_dist >= en)
                    t = 65536;
                else
                    t = longint'(($unsigned(walk_dist - st) << 16) / $unsigned(en - st));
                diff = longint'(s.a2) - longint'(s.a1);
                if (diff > PI_Q12)
                    diff -= TWO_PI_Q12;
                if (diff < -PI_Q12)
                    diff += TWO_PI_Q12;
                p.x = 32'(blend(s.sx, longint'(s.ex) - longint'(s.sx), t));
                p.y = 32'(blend(s.sy, longint'(s.ey) - longint'(s.sy), t));
                p.ang = 16'(blend(s.a1, diff, t));
                p.vld = 1'b1;
                walk_dist -= longint'(step);
            end
            expected_points.push_back(p);
        end
    endtask

    // Predict on every accepted input beat, compare on every output beat.
    always @(posedge clk or negedge rst_n)
    begin
        point_t got;
        point_t want;
        point_t p;
        if (!rst_n)
        begin
            newest = DEPTH - 1;
            nodes = 0;
            fail_count <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                case (op_t'(operation))
                    OP_PLOT:   add_segment(pos_x, pos_y, angle_in);
                    OP_SAMPLE: predict_samples(query_distance, interval, sample_count);
                    OP_HAS:
                    begin
                        p = '0;
                        p.vld = (nodes > 0);
                        p.pres = (nodes > 0) &&
                                 ($signed(query_distance) <=
                                  $signed({1'b0, trail[newest].ed}));
                        p.last = 1'b1;
                        expected_points.push_back(p);
                    end
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                got = {out_x, out_y, out_angle, valid_res, present, last_of_run};
                if (expected_points.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result beat %h", got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (got !== want)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: x %h/%h y %h/%h ang %h/%h v %b/%b p %b/%b l %b/%b",
                                     want.x, got.x, want.y, got.y, want.ang, got.ang,
                                     want.vld, got.vld, want.pres, got.pres,
                                     want.last, got.last);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

@@ verif/tb_top.sv @@
module tb_top;
    import talr_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  operation;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [15:0] angle_in;
    logic [48:0] query_distance;
    logic [31:0] interval;
    logic [6:0]  sample_count;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [15:0] out_angle;
    logic        valid_res;
    logic        present;
    logic        last_of_run;
    int          fail_count;
    int          pending;
    logic        hold_off;

    trail_arc_length_resampler_top dut (.*);

    talr_checker checker_i (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #200000000;
        $display("tb_top: errors");
        $finish;
    end

    // Receiver: a random stall pattern, plus one long hold-off stretch.
    initial
    begin
        int mode;
        out_ready = 1'b0;
        hold_off = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
                out_ready <= 1'b0;
            else
            begin
                mode = $urandom_range(0, 3);
                if (mode == 0)
                    out_ready <= 1'b1;
                else
                    out_ready <= ($urandom_range(0, 99) < 30 * mode);
            end
        end
    end

    // One beat on the input channel; holds until accepted.
    task automatic send_beat(input op_t op, input logic [31:0] x, input logic [31:0] y,
                             input logic [15:0] a, input logic [48:0] q,
                             input logic [31:0] stp, input logic [6:0] cnt);
        in_valid <= 1'b1;
        operation <= op;
        pos_x <= x;
        pos_y <= y;
        angle_in <= a;
        query_distance <= q;
        interval <= stp;
        sample_count <= cnt;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Valid drops only when a real gap follows, so the next beat never
    // lands in the same time step as the drop.
    task automatic idle_gap();
        int g;
        g = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return {{8{1'b0}}, 24'($urandom)};
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
        endcase
    endfunction

    function automatic logic [48:0] rand_dist();
        case ($urandom_range(0, 4))
            0: return 49'({$urandom, $urandom}) & 49'h1_FFFF_FFFF_FFFF;
            1: return 49'($urandom_range(0, 2000000)) << 4;
            2: return -49'($urandom_range(0, 100000));
            3: return {17'd0, $urandom};
            default: return 49'({$urandom, $urandom}) >> $urandom_range(0, 48);
        endcase
    endfunction

    initial
    begin
        int burst;
        int choice;
        in_valid = 1'b0;
        operation = OP_NONE;
        pos_x = '0;
        pos_y = '0;
        angle_in = '0;
        query_distance = '0;
        interval = '0;
        sample_count = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty path, extremes, heading wrap, zero and too-large counts.
        send_beat(OP_SAMPLE, 0, 0, 0, 49'd100, 32'd1, 7'd3);
        send_beat(OP_HAS, 0, 0, 0, 49'd0, 0, 7'd1);
        send_beat(OP_NONE, '1, '1, '1, '1, '1, '1);
        send_beat(OP_PLOT, 32'h8000_0000, 32'h8000_0000, 16'h8000, 0, 0, 0);
        send_beat(OP_PLOT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF, 0, 0, 0);
        send_beat(OP_PLOT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h3000, 0, 0, 0);
        send_beat(OP_PLOT, 32'h0001_0000, 32'hFFFF_0000, 16'hD000, 0, 0, 0);
        send_beat(OP_SAMPLE, 0, 0, 0, 49'h0_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 7'd6);
        send_beat(OP_SAMPLE, 0, 0, 0, 49'h1_0000_0000_0000, 32'h0, 7'd2);
        send_beat(OP_SAMPLE, 0, 0, 0, 49'h0_8000_0000_0000, 32'h1000_0000, 7'd0);
        send_beat(OP_SAMPLE, 0, 0, 0, 49'h0_8000_0000_0000, 32'h4000_0000, 7'd127);
        send_beat(OP_SAMPLE, 0, 0, 0, 49'h0_8000_0000_0000, 32'h8000_0000, 7'd64);
        send_beat(OP_HAS, 0, 0, 0, 49'h1_FFFF_FFFF_FFFF, 0, 0);
        send_beat(OP_HAS, 0, 0, 0, 49'h0_FFFF_FFFF_FFFF, 0, 0);
        send_beat(OP_HAS, 0, 0, 0, 49'h1_0000_0000_0000, 0, 0);

        // Long receiver hold-off while beats keep coming.
        fork
            begin
                hold_off = 1'b1;
                repeat (600) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 8; i++)
                send_beat(i % 2 ? OP_HAS : OP_SAMPLE, 0, 0, 0, rand_dist(),
                          $urandom, 7'($urandom_range(1, 4)));
        join

        // Random bursts, mostly plots and short samples, a few long walks.
        for (int n = 0; n < 410;)
        begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst; b++)
            begin
                choice = $urandom_range(0, 99);
                if (choice < 45)
                    send_beat(OP_PLOT, rand_coord(), rand_coord(), 16'($urandom), 0, 0, 0);
                else if (choice < 80)
                    send_beat(OP_SAMPLE, 0, 0, 0, rand_dist(),
                              ($urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 1 << 20))),
                              ($urandom_range(0, 15) == 0) ? 7'($urandom)
                                                           : 7'($urandom_range(1, 5)));
                else if (choice < 95)
                    send_beat(OP_HAS, $urandom, $urandom, 16'($urandom), rand_dist(), 0, 0);
                else
                    send_beat(OP_NONE, $urandom, $urandom, 16'($urandom), rand_dist(),
                              $urandom, 7'($urandom));
                n++;
            end
            idle_gap();
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
